// ----- rtl/oaht_pkg.sv -----
// ----------------------------------------------------------------------------
// Hash table package
// Shared widths, operation and status codes, slot marks, controller states
// and the hash weight function for the open-addressing hash table core.
// ----------------------------------------------------------------------------
package oaht_pkg;

	localparam int DEF_BUCKETS   = 1024;
	localparam int DEF_KEY_BYTES = 8;

	localparam int OP_W         = 2;
	localparam int KEY_PORT_W   = 64;
	localparam int SLOT_PORT_W  = 10;
	localparam int STATUS_W     = 3;
	localparam int COUNT_PORT_W = 11;

	typedef enum logic [OP_W-1:0] {
		OP_GET   = 2'd0,
		OP_PUT   = 2'd1,
		OP_DEL   = 2'd2,
		OP_CLEAR = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_FOUND   = 3'd0,
		ST_MISSING = 3'd1,
		ST_NEW     = 3'd2,
		ST_REUSED  = 3'd3,
		ST_FULL    = 3'd4,
		ST_DELETED = 3'd5,
		ST_IGNORED = 3'd6,
		ST_CLEARED = 3'd7
	} status_t;

	// bit 1 marks an empty slot, bit 0 a tombstone
	typedef enum logic [1:0] {
		MARK_LIVE  = 2'd0,
		MARK_TOMB  = 2'd1,
		MARK_EMPTY = 2'd2
	} mark_t;

	typedef enum logic [2:0] {
		S_SWEEP,
		S_IDLE,
		S_HASH,
		S_PROBE,
		S_DEL_RD,
		S_DEL_EV,
		S_RESULT
	} state_t;

	// 31^p modulo 2^32: weight of the key byte p positions above the last one
	function automatic logic [31:0] pow31(input int unsigned p);
		logic [31:0] r;
		r = 32'd1;
		for (int unsigned i = 0; i < p; i++) begin
			r = r * 32'd31;
		end
		return r;
	endfunction

endpackage

// ----- rtl/oaht_hash.sv -----
// ----------------------------------------------------------------------------
// Hash table home slot
// Registers the home slot of a key: the x31 byte hash, reduced to the low
// slot bits, computed as a weighted sum of the key bytes.
// ----------------------------------------------------------------------------
module oaht_hash #(
	parameter int KEY_BYTES = oaht_pkg::DEF_KEY_BYTES,
	parameter int SLOT_W    = 10
) (
	input  logic                   clk,
	input  logic                   load,
	input  logic [8*KEY_BYTES-1:0] key,
	output logic [SLOT_W-1:0]      home
);
	import oaht_pkg::*;

	logic [31:0]       term [KEY_BYTES];
	logic [31:0]       sum;
	logic [SLOT_W-1:0] home_q;

	for (genvar p = 0; p < KEY_BYTES; p++) begin : g_term
		localparam logic [31:0] WEIGHT = pow31(p);
		assign term[p] = 32'(key[8*p +: 8]) * WEIGHT;
	end

	always_comb begin
		sum = '0;
		for (int p = 0; p < KEY_BYTES; p++) begin
			sum = sum + term[p];
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			home_q <= SLOT_W'(sum);
		end
	end

	assign home = home_q;

endmodule

// ----- rtl/open_addressing_hash_table_core.sv -----
// ----------------------------------------------------------------------------
// Open-addressing hash table core
// Key table with triangular probing; get, put, delete by slot and clear.
// ----------------------------------------------------------------------------
// The table holds BUCKETS keys of KEY_BYTES bytes in two single-port style
// memories (keys and 2-bit slot marks) with a registered read. After reset
// the core sweeps every mark to empty, one slot per cycle, and holds
// in_ready low until the sweep is done. A get or put moves from idle through
// the hash, probe and result states, staying in the probe state while it
// walks. The probe pace is set by the mark/key memory read port: each probe
// issues the next address while the previous slot's data is examined.
// Delete passes through the delete read, delete evaluate and result states;
// clear reruns the mark sweep before the result state. A finished result
// sits in the output register, so the next request is accepted while it
// waits. result_slot addresses the external value memory.
// ----------------------------------------------------------------------------
module open_addressing_hash_table_core #(
	parameter int BUCKETS   = oaht_pkg::DEF_BUCKETS,
	parameter int KEY_BYTES = oaht_pkg::DEF_KEY_BYTES
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [oaht_pkg::OP_W-1:0]          opcode,
	input  logic [oaht_pkg::KEY_PORT_W-1:0]    lookup_key,
	input  logic [oaht_pkg::SLOT_PORT_W-1:0]   slot_index,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [oaht_pkg::SLOT_PORT_W-1:0]   result_slot,
	output logic [oaht_pkg::STATUS_W-1:0]      status,
	output logic [oaht_pkg::COUNT_PORT_W-1:0]  live_count
);
	import oaht_pkg::*;

	localparam int SLOT_W = $clog2(BUCKETS);
	localparam int KEY_W  = 8 * KEY_BYTES;
	localparam int LIVE_W = $clog2(BUCKETS + 1);
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(BUCKETS - 1);

	// control state
	state_t              state_q, state_n;
	logic [SLOT_W-1:0]   sweep_q;
	logic                clr_pend_q;
	logic [LIVE_W-1:0]   live_q;
	logic                out_valid_q;

	// request and walk registers
	op_t                 op_q;
	logic [KEY_W-1:0]    key_q;
	logic [SLOT_PORT_W-1:0] sel_q;
	logic [SLOT_W-1:0]   idx_q, home_q, step_q, site_q;
	logic                have_site_q;
	logic [SLOT_PORT_W-1:0] res_slot_q;
	status_t             res_status_q;
	logic [SLOT_PORT_W-1:0] out_slot_q;
	status_t             out_status_q;
	logic [COUNT_PORT_W-1:0] out_live_q;

	// memories
	mark_t               mark_mem [BUCKETS];
	logic [KEY_W-1:0]    key_mem  [BUCKETS];
	mark_t               mark_rd_q;
	logic [KEY_W-1:0]    key_rd_q;

	logic                rd_en, key_we, mark_we;
	logic [SLOT_W-1:0]   rd_addr, wr_addr;
	mark_t               mark_wdata;

	logic                accept, out_load;
	logic [SLOT_W-1:0]   hash_home;

	// probe evaluation
	logic                rd_empty, rd_tomb, key_hit, walk_on, wrap;
	logic [SLOT_W-1:0]   step_n, next_idx, site_n;
	logic                have_site_n;
	logic                fin, live_inc;
	logic [SLOT_W-1:0]   fin_slot;
	status_t             fin_status;

	// delete evaluation
	logic                sel_ok, del_hit;
	logic [SLOT_W-1:0]   sel_addr;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE);
	assign out_load = (state_q == S_RESULT) && (!out_valid_q || out_ready);

	oaht_hash #(
		.KEY_BYTES (KEY_BYTES),
		.SLOT_W    (SLOT_W)
	) u_hash (
		.clk  (clk),
		.load (accept),
		.key  (lookup_key[KEY_W-1:0]),
		.home (hash_home)
	);

	// Examine the slot read last cycle: keep walking past tombstones and
	// live slots holding another key.
	assign rd_empty = mark_rd_q[1];
	assign rd_tomb  = mark_rd_q[0];
	assign key_hit  = (key_rd_q == key_q);
	assign walk_on  = !rd_empty && (rd_tomb || !key_hit);
	assign step_n   = step_q + SLOT_W'(1);
	assign next_idx = idx_q + step_n;
	assign wrap     = walk_on && (next_idx == home_q);

	// only put remembers the last tombstone it passed
	assign site_n      = (op_q == OP_PUT && walk_on && rd_tomb) ? idx_q : site_q;
	assign have_site_n = have_site_q || (op_q == OP_PUT && walk_on && rd_tomb);

	assign sel_ok   = (32'(sel_q) < 32'(BUCKETS));
	assign sel_addr = SLOT_W'(sel_q);
	assign del_hit  = sel_ok && (mark_rd_q == MARK_LIVE);

	// next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			S_SWEEP: begin
				if (sweep_q == LAST_SLOT) begin
					state_n = clr_pend_q ? S_RESULT : S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					unique case (op_t'(opcode))
						OP_GET, OP_PUT: state_n = S_HASH;
						OP_DEL:         state_n = S_DEL_RD;
						OP_CLEAR:       state_n = S_SWEEP;
						default:        state_n = S_IDLE;
					endcase
				end
			end
			S_HASH:   state_n = S_PROBE;
			S_PROBE: begin
				if (fin) begin
					state_n = S_RESULT;
				end
			end
			S_DEL_RD: state_n = S_DEL_EV;
			S_DEL_EV: state_n = S_RESULT;
			S_RESULT: begin
				if (out_load) begin
					state_n = S_IDLE;
				end
			end
			default:  state_n = S_IDLE;
		endcase
	end

	// memory control and walk decisions
	always_comb begin
		rd_en      = 1'b0;
		rd_addr    = idx_q;
		key_we     = 1'b0;
		mark_we    = 1'b0;
		wr_addr    = idx_q;
		mark_wdata = MARK_EMPTY;
		fin        = 1'b0;
		fin_slot   = '0;
		fin_status = ST_MISSING;
		live_inc   = 1'b0;
		unique case (state_q)
			S_SWEEP: begin
				mark_we    = 1'b1;
				wr_addr    = sweep_q;
				mark_wdata = MARK_EMPTY;
			end
			S_HASH: begin
				rd_en   = 1'b1;
				rd_addr = hash_home;
			end
			S_PROBE: begin
				if (walk_on && !wrap) begin
					// advance to the next triangular offset
					rd_en   = 1'b1;
					rd_addr = next_idx;
				end else begin
					fin = 1'b1;
					if (op_q == OP_GET) begin
						if (!wrap && mark_rd_q == MARK_LIVE) begin
							fin_slot   = idx_q;
							fin_status = ST_FOUND;
						end
					end else if (wrap) begin
						if (have_site_n) begin
							fin_slot   = site_n;
							fin_status = ST_REUSED;
							live_inc   = 1'b1;
						end else begin
							fin_status = ST_FULL;
						end
					end else if (rd_empty) begin
						live_inc = 1'b1;
						if (have_site_n) begin
							fin_slot   = site_n;
							fin_status = ST_REUSED;
						end else begin
							fin_slot   = idx_q;
							fin_status = ST_NEW;
						end
					end else begin
						fin_slot   = idx_q;
						fin_status = ST_FOUND;
					end
					if (live_inc) begin
						key_we     = 1'b1;
						mark_we    = 1'b1;
						wr_addr    = fin_slot;
						mark_wdata = MARK_LIVE;
					end
				end
			end
			S_DEL_RD: begin
				rd_en   = sel_ok;
				rd_addr = sel_addr;
			end
			S_DEL_EV: begin
				if (del_hit) begin
					mark_we    = 1'b1;
					wr_addr    = sel_addr;
					mark_wdata = MARK_TOMB;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (key_we) begin
			key_mem[wr_addr] <= key_q;
		end
		if (mark_we) begin
			mark_mem[wr_addr] <= mark_wdata;
		end
		if (rd_en) begin
			mark_rd_q <= mark_mem[rd_addr];
			key_rd_q  <= key_mem[rd_addr];
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_SWEEP;
			sweep_q     <= '0;
			clr_pend_q  <= 1'b0;
			live_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			case (state_q)
				S_SWEEP: begin
					sweep_q <= sweep_q + SLOT_W'(1);
				end
				S_IDLE: begin
					if (accept && op_t'(opcode) == OP_CLEAR) begin
						sweep_q    <= '0;
						clr_pend_q <= 1'b1;
						live_q     <= '0;
					end
				end
				S_PROBE: begin
					if (live_inc) begin
						live_q <= live_q + LIVE_W'(1);
					end
				end
				S_DEL_EV: begin
					if (del_hit && live_q != '0) begin
						live_q <= live_q - LIVE_W'(1);
					end
				end
				S_RESULT: begin
					clr_pend_q <= 1'b0;
				end
				default: begin
				end
			endcase
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// request, walk and result registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					op_q         <= op_t'(opcode);
					key_q        <= lookup_key[KEY_W-1:0];
					sel_q        <= slot_index;
					res_slot_q   <= '0;
					res_status_q <= ST_CLEARED;
				end
			end
			S_HASH: begin
				idx_q       <= hash_home;
				home_q      <= hash_home;
				step_q      <= '0;
				site_q      <= '0;
				have_site_q <= 1'b0;
			end
			S_PROBE: begin
				site_q      <= site_n;
				have_site_q <= have_site_n;
				if (fin) begin
					res_slot_q   <= SLOT_PORT_W'(fin_slot);
					res_status_q <= fin_status;
				end else begin
					idx_q  <= next_idx;
					step_q <= step_n;
				end
			end
			S_DEL_EV: begin
				res_slot_q   <= sel_q;
				res_status_q <= del_hit ? ST_DELETED : ST_IGNORED;
			end
			S_RESULT: begin
				if (out_load) begin
					out_slot_q   <= res_slot_q;
					out_status_q <= res_status_q;
					out_live_q   <= COUNT_PORT_W'(live_q);
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid   = out_valid_q;
	assign result_slot = out_slot_q;
	assign status      = out_status_q;
	assign live_count  = out_live_q;

endmodule
